// ===== design/thc_pkg.sv =====
// Shared types, constants and fixed-point helpers for the temperature and humidity compensation.
package thc_pkg;

  localparam int QW          = 64;
  localparam int PW          = 2 * QW;
  localparam int MUL_DIGIT_W = 4;
  localparam int FRAC_W      = 32;

  localparam logic signed [QW-1:0] QMAX     = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [QW-1:0] QONE     = 64'sh0000_0001_0000_0000;
  localparam logic signed [QW-1:0] HUM_MAX  = 64'sh0000_0064_0000_0000;
  localparam logic signed [QW-1:0] TEMP_REF = 64'sd76800;

  localparam int FINE_SHIFT = 34;
  localparam int FINE_MAG_W = QW - FINE_SHIFT;
  localparam logic [5:0] DIV_CONST = 6'd20;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam logic [CFG_IDX_W-1:0] CFG_T1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_T2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_T3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_H2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_H4 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_H5 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_HS = 3'd6;

  typedef struct packed {
    logic          done;
    logic          neg;
    logic [PW-1:0] mag;
  } mul_res_t;

  function automatic logic signed [QW-1:0] q_exact(mul_res_t r);
    logic signed [QW-1:0] s;
    s = $signed(r.mag[QW-1:0]);
    return r.neg ? -s : s;
  endfunction

  function automatic logic signed [QW-1:0] q_frac(mul_res_t r);
    logic [PW-FRAC_W-1:0] m;
    logic signed [QW-1:0] s;
    m = r.mag[PW-1:FRAC_W];
    if (m > {{(PW-FRAC_W-QW){1'b0}}, QMAX}) begin
      s = QMAX;
    end else begin
      s = $signed(m[QW-1:0]);
    end
    return r.neg ? -s : s;
  endfunction

  function automatic logic signed [QW-1:0] sat_add(logic signed [QW-1:0] a,
                                                   logic signed [QW-1:0] b);
    logic signed [QW:0] s;
    logic signed [QW-1:0] res;
    s = {a[QW-1], a} + {b[QW-1], b};
    if (s[QW] != s[QW-1]) begin
      res = s[QW] ? -QMAX : QMAX;
    end else if (s[QW-1:0] == {1'b1, {(QW-1){1'b0}}}) begin
      res = -QMAX;
    end else begin
      res = s[QW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== design/thc_mul.sv =====
// Digit-serial signed multiplier giving the sign and full magnitude of a 64 by 64 product.
module thc_mul #(
  parameter int DIGIT_W = thc_pkg::MUL_DIGIT_W
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [thc_pkg::QW-1:0] a_i,
  input  logic signed [thc_pkg::QW-1:0] b_i,
  output thc_pkg::mul_res_t             res_o
);

  localparam int DIGITS = thc_pkg::QW / DIGIT_W;
  localparam int CNT_W  = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;
  logic                      neg_r, neg_nxt;
  logic [thc_pkg::QW-1:0]    ma_r, ma_nxt;
  logic [thc_pkg::QW-1:0]    mb_r, mb_nxt;
  logic [thc_pkg::PW-1:0]    acc_r, acc_nxt;
  logic [thc_pkg::QW+DIGIT_W-1:0] part;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    ma_nxt   = ma_r;
    mb_nxt   = mb_r;
    acc_nxt  = acc_r;
    part     = ma_r * mb_r[thc_pkg::QW-1 -: DIGIT_W];
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = a_i[thc_pkg::QW-1] ^ b_i[thc_pkg::QW-1];
      ma_nxt   = a_i[thc_pkg::QW-1] ? 0 - a_i : a_i;
      mb_nxt   = b_i[thc_pkg::QW-1] ? 0 - b_i : b_i;
      acc_nxt  = '0;
    end else if (busy_r) begin
      acc_nxt = (acc_r << DIGIT_W) + {{(thc_pkg::QW-DIGIT_W){1'b0}}, part};
      mb_nxt  = mb_r << DIGIT_W;
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIGITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    neg_r <= neg_nxt;
    ma_r  <= ma_nxt;
    mb_r  <= mb_nxt;
    acc_r <= acc_nxt;
  end

  assign res_o.done = done_r;
  assign res_o.neg  = neg_r;
  assign res_o.mag  = acc_r;

endmodule

// ===== design/temp_humidity_compensation.sv =====
// Top level: calibration registers, compensation sequencer and result register.
// A temperature transaction makes three passes of the shared digit-serial multiplier,
// then a serial division; a humidity transaction makes eight passes of it.
// One transaction is in work at a time; the next is accepted while a result waits to be taken.
// The fine temperature feeds the next humidity transaction, so the sequencer sets the rate.
// Synchronous active-low reset clears the calibration registers, fine temperature and control.
module temp_humidity_compensation #(
  parameter int MUL_DIGIT_W = thc_pkg::MUL_DIGIT_W
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_operation,
  input  logic [19:0]                          in_raw_sample,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [23:0]                   out_value,
  output logic signed [31:0]                   out_fine_temp,
  input  logic                                 cfg_we,
  input  logic [thc_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [thc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_T1   = 4'd1;
  localparam logic [3:0] ST_T2   = 4'd2;
  localparam logic [3:0] ST_T3   = 4'd3;
  localparam logic [3:0] ST_DIV  = 4'd4;
  localparam logic [3:0] ST_H1   = 4'd5;
  localparam logic [3:0] ST_H2   = 4'd6;
  localparam logic [3:0] ST_H3   = 4'd7;
  localparam logic [3:0] ST_H4   = 4'd8;
  localparam logic [3:0] ST_H5   = 4'd9;
  localparam logic [3:0] ST_H6   = 4'd10;
  localparam logic [3:0] ST_H7   = 4'd11;
  localparam logic [3:0] ST_H8   = 4'd12;
  localparam logic [3:0] ST_DONE = 4'd13;

  localparam int DIV_CNT_W = $clog2(thc_pkg::FINE_MAG_W);

  logic [15:0]        t1_r;
  logic signed [15:0] t2_r, t3_r, h2_r;
  logic signed [11:0] h4_r, h5_r;
  logic [23:0]        hs_r;

  logic [3:0]  state_r, state_nxt;
  logic        go_r, go_nxt;
  logic [19:0] raw_r;
  logic signed [31:0] fine_r, fine_nxt;
  logic signed [thc_pkg::QW-1:0] ra_r, ra_nxt, rb_r, rb_nxt, rc_r, rc_nxt;
  logic        fneg_r, fneg_nxt;
  logic [thc_pkg::FINE_MAG_W-1:0] dq_r, dq_nxt;
  logic [5:0]  rem_r, rem_nxt;
  logic [DIV_CNT_W-1:0] dcnt_r, dcnt_nxt;
  logic signed [23:0] pend_r, pend_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic signed [23:0] out_value_r, out_value_nxt;
  logic signed [31:0] out_fine_r, out_fine_nxt;

  logic signed [thc_pkg::QW-1:0] opa, opb, d64, x64, adc_off, n64, nmag, exact, frac, hr;
  logic [5:0] trial;
  thc_pkg::mul_res_t mres;

  thc_mul #(.DIGIT_W(MUL_DIGIT_W)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (go_r),
    .a_i   (opa),
    .b_i   (opb),
    .res_o (mres)
  );

  assign d64     = $signed({44'b0, raw_r}) - $signed({44'b0, t1_r, 4'b0});
  assign x64     = $signed({{32{fine_r[31]}}, fine_r}) - thc_pkg::TEMP_REF;
  assign adc_off = $signed({48'b0, raw_r[15:0]}) - $signed({{46{h4_r[11]}}, h4_r, 6'b0});
  assign exact   = thc_pkg::q_exact(mres);
  assign frac    = thc_pkg::q_frac(mres);
  assign n64     = (ra_r <<< 20) + exact;
  assign nmag    = n64[thc_pkg::QW-1] ? -n64 : n64;
  assign trial   = {rem_r[4:0], dq_r[thc_pkg::FINE_MAG_W-1]};

  always_comb begin
    case (state_r)
      ST_T1: begin
        opa = d64;
        opb = {{48{t2_r[15]}}, t2_r};
      end
      ST_T2: begin
        opa = d64;
        opb = d64;
      end
      ST_T3: begin
        opa = rb_r;
        opb = {{48{t3_r[15]}}, t3_r};
      end
      ST_H1: begin
        opa = {{52{h5_r[11]}}, h5_r};
        opb = x64;
      end
      ST_H2: begin
        opa = {56'b0, hs_r[15:8]};
        opb = x64;
      end
      ST_H3: begin
        opa = {{56{hs_r[23]}}, hs_r[23:16]};
        opb = x64;
      end
      ST_H4: begin
        opa = rc_r;
        opb = rb_r;
      end
      ST_H5: begin
        opa = {{32{h2_r[15]}}, h2_r, 16'b0};
        opb = rc_r;
      end
      ST_H6: begin
        opa = ra_r;
        opb = rc_r;
      end
      ST_H7: begin
        opa = rb_r;
        opb = {43'b0, hs_r[7:0], 13'b0};
      end
      ST_H8: begin
        opa = rb_r;
        opb = rc_r;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  always_comb begin
    if (frac[thc_pkg::QW-1]) begin
      hr = '0;
    end else if (frac > thc_pkg::HUM_MAX) begin
      hr = thc_pkg::HUM_MAX;
    end else begin
      hr = frac;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    go_nxt        = 1'b0;
    fine_nxt      = fine_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rc_nxt        = rc_r;
    fneg_nxt      = fneg_r;
    dq_nxt        = dq_r;
    rem_nxt       = rem_r;
    dcnt_nxt      = dcnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    out_value_nxt = out_value_r;
    out_fine_nxt  = out_fine_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_operation ? ST_H1 : ST_T1;
          go_nxt    = 1'b1;
        end
      end
      ST_T1, ST_T2, ST_T3, ST_H1, ST_H2, ST_H3, ST_H4, ST_H5, ST_H6, ST_H7, ST_H8: begin
        if (mres.done && !go_r) begin
          go_nxt    = 1'b1;
          state_nxt = state_r + 4'd1;
          case (state_r)
            ST_T1: ra_nxt = exact;
            ST_T2: rb_nxt = exact;
            ST_T3: begin
              fneg_nxt  = n64[thc_pkg::QW-1];
              dq_nxt    = nmag[thc_pkg::QW-1:thc_pkg::FINE_SHIFT];
              fine_nxt  = n64[thc_pkg::QW-1] ?
                          -$signed({2'b0, nmag[thc_pkg::QW-1:thc_pkg::FINE_SHIFT]}) :
                          $signed({2'b0, nmag[thc_pkg::QW-1:thc_pkg::FINE_SHIFT]});
              rem_nxt   = '0;
              dcnt_nxt  = '0;
              go_nxt    = 1'b0;
              state_nxt = ST_DIV;
            end
            ST_H1: ra_nxt = (adc_off <<< 32) - (exact <<< 18);
            ST_H2: rb_nxt = thc_pkg::QONE + (exact <<< 6);
            ST_H3: rc_nxt = exact <<< 6;
            ST_H4: rc_nxt = thc_pkg::sat_add(thc_pkg::QONE, frac);
            ST_H5: rc_nxt = frac;
            ST_H6: rb_nxt = frac;
            ST_H7: rc_nxt = thc_pkg::sat_add(thc_pkg::QONE, -frac);
            ST_H8: begin
              pend_nxt  = hr[45:22];
              go_nxt    = 1'b0;
              state_nxt = ST_DONE;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        if (trial >= thc_pkg::DIV_CONST) begin
          rem_nxt = trial - thc_pkg::DIV_CONST;
          dq_nxt  = {dq_r[thc_pkg::FINE_MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          dq_nxt  = {dq_r[thc_pkg::FINE_MAG_W-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r + 1'b1;
        if (dcnt_r == DIV_CNT_W'(thc_pkg::FINE_MAG_W - 1)) begin
          pend_nxt  = fneg_r ? -$signed(dq_nxt[23:0]) : $signed(dq_nxt[23:0]);
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = pend_r;
          out_fine_nxt  = fine_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      fine_r      <= '0;
      t1_r        <= '0;
      t2_r        <= '0;
      t3_r        <= '0;
      h2_r        <= '0;
      h4_r        <= '0;
      h5_r        <= '0;
      hs_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      go_r        <= go_nxt;
      out_valid_r <= out_valid_nxt;
      fine_r      <= fine_nxt;
      if (cfg_we) begin
        case (cfg_index)
          thc_pkg::CFG_T1: t1_r <= cfg_data[15:0];
          thc_pkg::CFG_T2: t2_r <= cfg_data[15:0];
          thc_pkg::CFG_T3: t3_r <= cfg_data[15:0];
          thc_pkg::CFG_H2: h2_r <= cfg_data[15:0];
          thc_pkg::CFG_H4: h4_r <= cfg_data[11:0];
          thc_pkg::CFG_H5: h5_r <= cfg_data[11:0];
          thc_pkg::CFG_HS: hs_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      raw_r <= in_raw_sample;
    end
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    rc_r        <= rc_nxt;
    fneg_r      <= fneg_nxt;
    dq_r        <= dq_nxt;
    rem_r       <= rem_nxt;
    dcnt_r      <= dcnt_nxt;
    pend_r      <= pend_nxt;
    out_value_r <= out_value_nxt;
    out_fine_r  <= out_fine_nxt;
  end

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_value     = out_value_r;
  assign out_fine_temp = out_fine_r;

endmodule

// ===== design/thc_checker.sv =====
// Port-level checker for the compensation block and its bind to the top level.
module thc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [23:0] out_value,
  input logic signed [31:0] out_fine_temp
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_fine_temp))
    else $error("Stalled result changed or was dropped.");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("Block accepted a transaction while another was in work.");

  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready)
    else $error("Result appeared without the sequencer returning to idle.");

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind temp_humidity_compensation thc_checker u_thc_checker (.*);
